FILE: rtl/core/esfr_pkg.sv
// Shared types and constants for the escape-stuffed frame receiver.
// Used by the channel interfaces and every module of the block.
package esfr_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned LEN_W     = 7;
  localparam int unsigned ERR_W     = 16;
  localparam int unsigned CNT_W     = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 8;

  // Command queue between front and back.
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CW    = $clog2(Q_DEPTH + 1);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ESCAPE_BYTE  = 3'd0,
    CFG_START_A_CODE = 3'd1,
    CFG_START_B_CODE = 3'd2,
    CFG_END_CODE     = 3'd3,
    CFG_LIT_CODE     = 3'd4,
    CFG_DBL_CODE     = 3'd5
  } cfg_idx_t;

  localparam logic [BYTE_W-1:0] RST_ESCAPE_BYTE  = 8'd27;
  localparam logic [BYTE_W-1:0] RST_START_A_CODE = 8'd2;
  localparam logic [BYTE_W-1:0] RST_START_B_CODE = 8'd3;
  localparam logic [BYTE_W-1:0] RST_END_CODE     = 8'd7;
  localparam logic [BYTE_W-1:0] RST_LIT_CODE     = 8'd8;
  localparam logic [BYTE_W-1:0] RST_DBL_CODE     = 8'd9;

  typedef struct packed {
    logic [BYTE_W-1:0] escape_byte;
    logic [BYTE_W-1:0] start_a_code;
    logic [BYTE_W-1:0] start_b_code;
    logic [BYTE_W-1:0] end_code;
    logic [BYTE_W-1:0] lit_code;
    logic [BYTE_W-1:0] dbl_code;
  } cfg_t;

  // Meaning of a byte when it follows an escape, first match wins.
  typedef enum logic [2:0] {
    CODE_NONE,
    CODE_START_A,
    CODE_START_B,
    CODE_END,
    CODE_LIT,
    CODE_DBL
  } code_kind_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              is_esc;
    code_kind_t        kind;
  } q_entry_t;

  typedef struct packed {
    logic [CNT_W-1:0]  data_count;
    logic [BYTE_W-1:0] data_first;
    logic [BYTE_W-1:0] data_second;
    logic              frame_start;
    logic              frame_done;
    logic              frame_is_type_a;
    logic              protocol_error;
    logic [ERR_W-1:0]  error_total;
    logic              dropped_full;
    logic [LEN_W-1:0]  frame_length;
  } result_t;

endpackage

FILE: rtl/core/esfr_in_if.sv
// Input byte channel: valid/ready handshake carrying one line byte.
// Depends on esfr_pkg for the byte width.
interface esfr_in_if;
  logic                       valid;
  logic                       ready;
  logic [esfr_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: rtl/core/esfr_out_if.sv
// Result channel: valid/ready handshake carrying one decoded result word.
// Depends on esfr_pkg for the field widths.
interface esfr_out_if;
  logic                        valid;
  logic                        ready;
  logic [esfr_pkg::CNT_W-1:0]  data_count;
  logic [esfr_pkg::BYTE_W-1:0] data_first;
  logic [esfr_pkg::BYTE_W-1:0] data_second;
  logic                        frame_start;
  logic                        frame_done;
  logic                        frame_is_type_a;
  logic                        protocol_error;
  logic [esfr_pkg::ERR_W-1:0]  error_total;
  logic                        dropped_full;
  logic [esfr_pkg::LEN_W-1:0]  frame_length;

  modport source (output valid, output data_count, output data_first, output data_second,
                  output frame_start, output frame_done, output frame_is_type_a,
                  output protocol_error, output error_total, output dropped_full,
                  output frame_length, input ready);
  modport sink   (input valid, input data_count, input data_first, input data_second,
                  input frame_start, input frame_done, input frame_is_type_a,
                  input protocol_error, input error_total, input dropped_full,
                  input frame_length, output ready);
endinterface

FILE: rtl/core/escape_stuffed_frame_receiver.sv
// Escape-stuffed frame receiver: top level.
// Depends on esfr_pkg, esfr_in_if, esfr_out_if, esfr_front, esfr_queue, esfr_back.
//
// Usage:
//   in_ch  - one line byte per word (rx_byte), valid/ready handshake.
//   out_ch - exactly one result word per accepted byte, in order: delivered
//            payload bytes (0 to 2), frame start/done, frame type, error flag,
//            running error total, drop flag and current frame length.
//   cfg_*  - write port for the six code registers (escape byte, start A,
//            start B, end, literal escape, double escape); write only while
//            the block holds no byte in flight. Indexes 6 and 7 are ignored.
// Timing: a byte is classified and queued in its accept cycle; the back end
//   then pops it, updates the frame state and registers its result word
//   together, and out_ch shows that register. Throughput is one byte per
//   cycle while out_ch is ready and the queue holds bytes.
// Reset (rst_n low, synchronous) clears the queue, the frame state, the
//   error counter and the result valid flag and reloads the default codes.
// When out_ch stalls, the result register holds its word and the two-entry
//   queue keeps accepting until it fills; in_ch.ready then drops.
module escape_stuffed_frame_receiver #(
  parameter int unsigned FRAME_LIMIT = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  esfr_in_if.sink                         in_ch,
  esfr_out_if.source                      out_ch,
  input  logic                            cfg_wr_en,
  input  logic [esfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [esfr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  esfr_pkg::cfg_t     cfg_r;
  logic               q_push;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;
  esfr_pkg::q_entry_t q_in;
  esfr_pkg::q_entry_t q_head;
  esfr_pkg::result_t  res;
  logic               res_valid;

  // Code registers: load defaults at reset, update on a write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.escape_byte  <= esfr_pkg::RST_ESCAPE_BYTE;
      cfg_r.start_a_code <= esfr_pkg::RST_START_A_CODE;
      cfg_r.start_b_code <= esfr_pkg::RST_START_B_CODE;
      cfg_r.end_code     <= esfr_pkg::RST_END_CODE;
      cfg_r.lit_code     <= esfr_pkg::RST_LIT_CODE;
      cfg_r.dbl_code     <= esfr_pkg::RST_DBL_CODE;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        esfr_pkg::CFG_ESCAPE_BYTE:  cfg_r.escape_byte  <= cfg_wdata;
        esfr_pkg::CFG_START_A_CODE: cfg_r.start_a_code <= cfg_wdata;
        esfr_pkg::CFG_START_B_CODE: cfg_r.start_b_code <= cfg_wdata;
        esfr_pkg::CFG_END_CODE:     cfg_r.end_code     <= cfg_wdata;
        esfr_pkg::CFG_LIT_CODE:     cfg_r.lit_code     <= cfg_wdata;
        esfr_pkg::CFG_DBL_CODE:     cfg_r.dbl_code     <= cfg_wdata;
        default: ; // drop writes to unused indexes
      endcase
    end
  end

  // Front: accept and classify each byte against the current codes.
  esfr_front u_front (
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (q_in)
  );

  // Queue decouples the front from a stalled back end.
  esfr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .head       (q_head),
    .full       (q_full),
    .empty      (q_empty)
  );

  // Back: advance frame state and register one result per byte.
  esfr_back #(
    .FRAME_LIMIT (FRAME_LIMIT)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .escape_byte (cfg_r.escape_byte),
    .head        (q_head),
    .q_empty     (q_empty),
    .pop         (q_pop),
    .res         (res),
    .res_valid   (res_valid),
    .res_ready   (out_ch.ready)
  );

  assign out_ch.valid           = res_valid;
  assign out_ch.data_count      = res.data_count;
  assign out_ch.data_first      = res.data_first;
  assign out_ch.data_second     = res.data_second;
  assign out_ch.frame_start     = res.frame_start;
  assign out_ch.frame_done      = res.frame_done;
  assign out_ch.frame_is_type_a = res.frame_is_type_a;
  assign out_ch.protocol_error  = res.protocol_error;
  assign out_ch.error_total     = res.error_total;
  assign out_ch.dropped_full    = res.dropped_full;
  assign out_ch.frame_length    = res.frame_length;

  // An accepted byte is in the queue in the cycle after its acceptance.
  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !q_empty)
    else $error("accepted byte missing from queue");

  a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_full && q_empty))
    else $error("queue full and empty at once");

  a_drop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.dropped_full) |->
      (!out_ch.protocol_error && !out_ch.frame_start && !out_ch.frame_done &&
       out_ch.data_count == 2'd0))
    else $error("dropped byte changed frame state");

  a_start_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.frame_start && out_ch.frame_done))
    else $error("frame start and done on one byte");

endmodule

FILE: rtl/core/esfr_front.sv
// Front end: accepts line bytes and classifies them against the code registers.
// Depends on esfr_pkg and esfr_in_if.
module esfr_front (
  esfr_in_if.sink           in_ch,
  input  esfr_pkg::cfg_t    cfg,
  input  logic              q_full,
  output logic              push,
  output esfr_pkg::q_entry_t push_entry
);

  esfr_pkg::code_kind_t kind;

  always_comb begin
    priority if (in_ch.rx_byte == cfg.start_a_code) begin
      kind = esfr_pkg::CODE_START_A;
    end else if (in_ch.rx_byte == cfg.start_b_code) begin
      kind = esfr_pkg::CODE_START_B;
    end else if (in_ch.rx_byte == cfg.end_code) begin
      kind = esfr_pkg::CODE_END;
    end else if (in_ch.rx_byte == cfg.lit_code) begin
      kind = esfr_pkg::CODE_LIT;
    end else if (in_ch.rx_byte == cfg.dbl_code) begin
      kind = esfr_pkg::CODE_DBL;
    end else begin
      kind = esfr_pkg::CODE_NONE;
    end
  end

  assign in_ch.ready        = !q_full;
  assign push               = in_ch.valid && !q_full;
  assign push_entry.rx_byte = in_ch.rx_byte;
  assign push_entry.is_esc  = (in_ch.rx_byte == cfg.escape_byte);
  assign push_entry.kind    = kind;

endmodule

FILE: rtl/core/esfr_queue.sv
// Short command queue between the classifying front and the state back end.
// Depends on esfr_pkg for the entry type and depth.
module esfr_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  esfr_pkg::q_entry_t push_entry,
  input  logic               pop,
  output esfr_pkg::q_entry_t head,
  output logic               full,
  output logic               empty
);

  localparam logic [esfr_pkg::Q_AW-1:0] LAST = esfr_pkg::Q_AW'(esfr_pkg::Q_DEPTH - 1);
  localparam logic [esfr_pkg::Q_CW-1:0] DEPTH_C = esfr_pkg::Q_CW'(esfr_pkg::Q_DEPTH);

  esfr_pkg::q_entry_t               mem_r [esfr_pkg::Q_DEPTH];
  logic [esfr_pkg::Q_AW-1:0]        wptr_r, wptr_nxt;
  logic [esfr_pkg::Q_AW-1:0]        rptr_r, rptr_nxt;
  logic [esfr_pkg::Q_CW-1:0]        count_r, count_nxt;

  assign full  = (count_r == DEPTH_C);
  assign empty = (count_r == '0);
  assign head  = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == LAST) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == LAST) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_entry;
    end
  end

endmodule

FILE: rtl/core/esfr_back.sv
// Back end: frame state, error counter and the registered result word.
// Depends on esfr_pkg for the entry and result types.
module esfr_back #(
  parameter int unsigned FRAME_LIMIT = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [esfr_pkg::BYTE_W-1:0] escape_byte,
  input  esfr_pkg::q_entry_t          head,
  input  logic                        q_empty,
  output logic                        pop,
  output esfr_pkg::result_t           res,
  output logic                        res_valid,
  input  logic                        res_ready
);

  // Limit in effect, clipped to what the length counter can hold.
  localparam int unsigned LEN_MAX = (1 << esfr_pkg::LEN_W) - 1;
  localparam logic [esfr_pkg::LEN_W-1:0] LIM =
    esfr_pkg::LEN_W'((FRAME_LIMIT > LEN_MAX) ? LEN_MAX : FRAME_LIMIT);

  logic                         esc_pend_r, esc_pend_nxt;
  logic                         in_frame_r, in_frame_nxt;
  logic                         type_a_r, type_a_nxt;
  logic [esfr_pkg::LEN_W-1:0]   len_r, len_nxt;
  logic [esfr_pkg::ERR_W-1:0]   err_cnt_r, err_cnt_nxt;
  esfr_pkg::result_t            res_r, res_nxt;
  logic                         res_valid_r;
  logic                         err;
  logic [esfr_pkg::LEN_W-1:0]   len_inc;

  assign pop     = !q_empty && (!res_valid_r || res_ready);
  assign len_inc = len_r + 1'b1;

  always_comb begin
    esc_pend_nxt = esc_pend_r;
    in_frame_nxt = in_frame_r;
    type_a_nxt   = type_a_r;
    len_nxt      = len_r;
    err          = 1'b0;
    res_nxt      = '0;

    if (len_r >= LIM) begin
      // Buffer full: drop, keep every flag.
      res_nxt.dropped_full = 1'b1;
    end else if (esc_pend_r) begin
      esc_pend_nxt = 1'b0;
      unique case (head.kind)
        esfr_pkg::CODE_START_A, esfr_pkg::CODE_START_B: begin
          err                 = in_frame_r;
          in_frame_nxt        = 1'b1;
          len_nxt             = '0;
          type_a_nxt          = (head.kind == esfr_pkg::CODE_START_A);
          res_nxt.frame_start = 1'b1;
        end
        esfr_pkg::CODE_END: begin
          if (!in_frame_r) begin
            err = 1'b1;
          end else begin
            in_frame_nxt       = 1'b0;
            res_nxt.frame_done = 1'b1;
          end
        end
        esfr_pkg::CODE_LIT: begin
          if (!in_frame_r) begin
            err = 1'b1;
          end else begin
            res_nxt.data_count = 2'd1;
            res_nxt.data_first = escape_byte;
            len_nxt            = len_inc;
          end
        end
        esfr_pkg::CODE_DBL: begin
          if (!in_frame_r) begin
            err = 1'b1;
          end else begin
            res_nxt.data_count = 2'd1;
            res_nxt.data_first = escape_byte;
            len_nxt            = len_inc;
            // Second copy only if room is left.
            if (len_inc < LIM) begin
              res_nxt.data_count  = 2'd2;
              res_nxt.data_second = escape_byte;
              len_nxt             = len_inc + 1'b1;
            end
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase
    end else if (head.is_esc) begin
      esc_pend_nxt = 1'b1;
    end else if (!in_frame_r) begin
      err = 1'b1;
    end else begin
      res_nxt.data_count = 2'd1;
      res_nxt.data_first = head.rx_byte;
      len_nxt            = len_inc;
    end

    err_cnt_nxt             = err_cnt_r + esfr_pkg::ERR_W'(err);
    res_nxt.protocol_error  = err;
    res_nxt.error_total     = err_cnt_nxt;
    res_nxt.frame_is_type_a = type_a_nxt;
    res_nxt.frame_length    = len_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_pend_r  <= 1'b0;
      in_frame_r  <= 1'b0;
      type_a_r    <= 1'b0;
      len_r       <= '0;
      err_cnt_r   <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        esc_pend_r  <= esc_pend_nxt;
        in_frame_r  <= in_frame_nxt;
        type_a_r    <= type_a_nxt;
        len_r       <= len_nxt;
        err_cnt_r   <= err_cnt_nxt;
        res_valid_r <= 1'b1;
      end else if (res_ready) begin
        res_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      res_r <= res_nxt;
    end
  end

  assign res       = res_r;
  assign res_valid = res_valid_r;

endmodule
